/* hdl/mwnh_pkg.sv */
`timescale 1ns / 1ps

package mwnh_pkg;

	// Field widths
	localparam int TOKEN_W = 32;
	localparam int WAY_W   = 4;
	localparam int SLOT_W  = 16;

	// Ways per token triple, 1 to 16
	localparam int NUM_WAYS = 16;
	localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(NUM_WAYS - 1);

	// Table size is 2**TABLE_LOG2 entries (1 to 16), so the modulo is a mask
	localparam int TABLE_LOG2 = 16;
	localparam logic [63:0] SLOT_MASK = (64'd1 << TABLE_LOG2) - 64'd1;

	// Mix multipliers
	localparam logic [31:0] MIX_MUL_A = 32'h85ebca6b;
	localparam logic [31:0] MIX_MUL_B = 32'hc2b2ae35;

	// Per-way prime and its square
	localparam int PRIME_W    = 7;
	localparam int PRIME_SQ_W = 14;
	typedef logic [PRIME_W-1:0]    prime_t;
	typedef logic [PRIME_SQ_W-1:0] prime_sq_t;

	localparam prime_t WAY_PRIME [16] = '{
		7'd31, 7'd37, 7'd41, 7'd43, 7'd47, 7'd53, 7'd59, 7'd61,
		7'd67, 7'd71, 7'd73, 7'd79, 7'd83, 7'd89, 7'd97, 7'd101
	};

	localparam prime_sq_t WAY_PRIME_SQ [16] = '{
		14'd961,  14'd1369, 14'd1681, 14'd1849, 14'd2209, 14'd2809, 14'd3481, 14'd3721,
		14'd4489, 14'd5041, 14'd5329, 14'd6241, 14'd6889, 14'd7921, 14'd9409, 14'd10201
	};

	// Polynomial term widths; their sum never wraps 64 bits
	localparam int M1_W = TOKEN_W + PRIME_W;
	localparam int M2_W = TOKEN_W + PRIME_SQ_W;
	localparam int H0_W = M2_W + 1;

	// One way request from the sequencer into the hash pipeline
	typedef struct packed {
		logic               valid;
		logic               last;
		logic [WAY_W-1:0]   way;
		logic [TOKEN_W-1:0] prev2;
		logic [TOKEN_W-1:0] prev1;
		logic [TOKEN_W-1:0] curr;
	} way_req_t;

endpackage

/* hdl/multi_way_ngram_hash_slot.sv */
`timescale 1ns / 1ps

// Multi-way n-gram hash slot generator.
// Input channel (in_valid/in_ready): one request carries a token triple
// token_prev2, token_prev1, token_curr.
// Output channel (out_valid/out_ready): each triple yields NUM_WAYS results,
// way_index 0..NUM_WAYS-1 in order, slot_index is the table row for that way,
// last_way marks the final way of the triple.
// Throughput: one result per cycle while the receiver does not stall, so one
// triple per NUM_WAYS results; the way sequencer issues one way per cycle into
// a six-stage hash pipeline unless the output stalls, and accepts the next
// triple in the cycle its last way is issued. A triple's results leave
// stage S6 in way order, each way having passed the issue register and S1..S6.
// The pipeline is split at each of the two 64-bit mix multiplies (each into
// two 32-bit partial products) and their recombining adds.
// Reset clears the sequencer and all stage valids; the held tokens and payload registers are not reset.
// When the receiver stalls, the whole pipeline holds in place and the output
// stays unchanged; a new triple is still taken while the sequencer is idle.
module multi_way_ngram_hash_slot import mwnh_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [TOKEN_W-1:0] token_prev2,
	input  logic [TOKEN_W-1:0] token_prev1,
	input  logic [TOKEN_W-1:0] token_curr,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [WAY_W-1:0]   way_index,
	output logic [SLOT_W-1:0]  slot_index,
	output logic               last_way
);

	way_req_t req;
	logic     adv;

	mwnh_issue u_issue (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.token_prev2 (token_prev2),
		.token_prev1 (token_prev1),
		.token_curr  (token_curr),
		.adv         (adv),
		.req         (req)
	);

	mwnh_mix_pipe u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.adv        (adv),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.way_index  (way_index),
		.slot_index (slot_index),
		.last_way   (last_way)
	);

`ifndef ASSERT_OFF
	// Last flag matches the final way number
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_way == (way_index == LAST_WAY)))
		else $error("last_way does not match way_index");

	// An accepted triple starts at way zero
	a_start_way: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (req.valid && req.way == '0))
		else $error("new triple did not start at way zero");

	// A stalled output freezes a busy sequencer
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && req.valid) |=> ($stable(req.way) && $stable(req.valid)))
		else $error("sequencer advanced during output stall");
`endif

endmodule

/* hdl/mwnh_issue.sv */
`timescale 1ns / 1ps

module mwnh_issue import mwnh_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [TOKEN_W-1:0] token_prev2,
	input  logic [TOKEN_W-1:0] token_prev1,
	input  logic [TOKEN_W-1:0] token_curr,
	input  logic               adv,
	output way_req_t           req
);

	logic               busy_q;
	logic [WAY_W-1:0]   way_q;
	logic [TOKEN_W-1:0] prev2_q;
	logic [TOKEN_W-1:0] prev1_q;
	logic [TOKEN_W-1:0] curr_q;
	logic               on_last;
	logic               in_accept;

	assign on_last   = (way_q == LAST_WAY);
	// Take the next triple as soon as the last way of the current one moves on
	assign in_ready  = !busy_q || (adv && on_last);
	assign in_accept = in_valid && in_ready;

	// Way counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			way_q  <= '0;
		end else if (in_accept) begin
			busy_q <= 1'b1;
			way_q  <= '0;
		end else if (adv && busy_q) begin
			if (on_last) begin
				busy_q <= 1'b0;
			end else begin
				way_q <= way_q + WAY_W'(1);
			end
		end
	end

	// Held token triple
	always_ff @(posedge clk) begin
		if (in_accept) begin
			prev2_q <= token_prev2;
			prev1_q <= token_prev1;
			curr_q  <= token_curr;
		end
	end

	always_comb begin
		req.valid = busy_q;
		req.last  = on_last;
		req.way   = way_q;
		req.prev2 = prev2_q;
		req.prev1 = prev1_q;
		req.curr  = curr_q;
	end

endmodule

/* hdl/mwnh_mix_pipe.sv */
`timescale 1ns / 1ps

module mwnh_mix_pipe import mwnh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  way_req_t          req,
	output logic              adv,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WAY_W-1:0]  way_index,
	output logic [SLOT_W-1:0] slot_index,
	output logic              last_way
);

	// Stage valids
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// Way tag and last flag ride along
	logic [WAY_W-1:0] way_s1, way_s2, way_s3, way_s4, way_s5, way_s6;
	logic             last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;

	// Datapath
	logic [M1_W-1:0]    m1_s1;
	logic [M2_W-1:0]    m2_s1;
	logic [TOKEN_W-1:0] curr_s1;
	logic [H0_W-1:0]    x_s2;
	logic [63:0]        plo_s3;
	logic [31:0]        phi_s3;
	logic [63:0]        y_s4;
	logic [63:0]        qlo_s5;
	logic [31:0]        qhi_s5;
	logic [SLOT_W-1:0]  slot_s6;

	logic [M1_W-1:0]  m1_d;
	logic [M2_W-1:0]  m2_d;
	logic [H0_W-1:0]  h0_d;
	logic [H0_W-1:0]  x_d;
	logic [63:0]      plo_d;
	logic [46:0]      phi_full_d;
	logic [63:0]      h1_d;
	logic [63:0]      y_d;
	logic [63:0]      qlo_d;
	logic [63:0]      qhi_full_d;
	logic [63:0]      h2_d;
	logic [63:0]      z_d;

	// Whole pipe moves unless the output register is full and stalled
	assign adv = !v_s6 || out_ready;

	// S1: prev1*p and prev2*p*p
	assign m1_d = M1_W'(req.prev1) * M1_W'(WAY_PRIME[req.way]);
	assign m2_d = M2_W'(req.prev2) * M2_W'(WAY_PRIME_SQ[req.way]);

	// S2: polynomial sum, first xor-shift
	assign h0_d = H0_W'(curr_s1) + H0_W'(m1_s1) + H0_W'(m2_s1);
	assign x_d  = h0_d ^ (h0_d >> 16);

	// S3: x * A split into low and high partial products
	assign plo_d      = 64'(x_s2[31:0]) * 64'(MIX_MUL_A);
	assign phi_full_d = 47'(x_s2[H0_W-1:32]) * 47'(MIX_MUL_A);

	// S4: recombine mod 2^64, second xor-shift
	assign h1_d = plo_s3 + {phi_s3, 32'd0};
	assign y_d  = h1_d ^ (h1_d >> 13);

	// S5: y * B split into low and high partial products
	assign qlo_d      = 64'(y_s4[31:0]) * 64'(MIX_MUL_B);
	assign qhi_full_d = 64'(y_s4[63:32]) * 64'(MIX_MUL_B);

	// S6: recombine, final xor-shift, reduce to table row
	assign h2_d = qlo_s5 + {qhi_s5, 32'd0};
	assign z_d  = h2_d ^ (h2_d >> 16);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			way_s1  <= req.way;
			last_s1 <= req.last;
			m1_s1   <= m1_d;
			m2_s1   <= m2_d;
			curr_s1 <= req.curr;

			way_s2  <= way_s1;
			last_s2 <= last_s1;
			x_s2    <= x_d;

			way_s3  <= way_s2;
			last_s3 <= last_s2;
			plo_s3  <= plo_d;
			phi_s3  <= phi_full_d[31:0];

			way_s4  <= way_s3;
			last_s4 <= last_s3;
			y_s4    <= y_d;

			way_s5  <= way_s4;
			last_s5 <= last_s4;
			qlo_s5  <= qlo_d;
			qhi_s5  <= qhi_full_d[31:0];

			way_s6  <= way_s5;
			last_s6 <= last_s5;
			slot_s6 <= SLOT_W'(z_d & SLOT_MASK);
		end
	end

	assign out_valid  = v_s6;
	assign way_index  = way_s6;
	assign slot_index = slot_s6;
	assign last_way   = last_s6;

endmodule

/* tb/multi_way_ngram_hash_slot_tb.sv */
`timescale 1ns / 1ps

module multi_way_ngram_hash_slot_tb import mwnh_pkg::*; ();

	localparam int N_RANDOM       = 285;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 24;

	// Avalanche multipliers and the per-way primes, in way order
	localparam logic [63:0] AVAL_MUL_A = 64'h0000_0000_85eb_ca6b;
	localparam logic [63:0] AVAL_MUL_B = 64'h0000_0000_c2b2_ae35;
	localparam logic [63:0] NGRAM_PRIME [16] = '{
		64'd31, 64'd37, 64'd41, 64'd43, 64'd47, 64'd53, 64'd59, 64'd61,
		64'd67, 64'd71, 64'd73, 64'd79, 64'd83, 64'd89, 64'd97, 64'd101
	};

	typedef struct packed {
		logic [TOKEN_W-1:0] prev2;
		logic [TOKEN_W-1:0] prev1;
		logic [TOKEN_W-1:0] curr;
	} token_triple_t;

	typedef struct packed {
		logic [WAY_W-1:0]  way;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} way_slot_t;

	// Receiver stall styles
	typedef enum logic [1:0] {
		RX_FREE,
		RX_SPOTTY,
		RX_RUNS,
		RX_PERIODIC
	} rx_mode_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic [TOKEN_W-1:0] token_prev2 = '0;
	logic [TOKEN_W-1:0] token_prev1 = '0;
	logic [TOKEN_W-1:0] token_curr  = '0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic [WAY_W-1:0]   way_index;
	logic [SLOT_W-1:0]  slot_index;
	logic               last_way;

	token_triple_t triple_queue[$];
	way_slot_t     slot_expect[$];
	token_triple_t drv_triple;
	way_slot_t     due;

	int  n_directed     = 0;
	int  n_total        = 0;
	int  n_accepted     = 0;
	int  n_checked      = 0;
	int  fail_count     = 0;
	int  burst_left     = 4;
	int  gap_left       = 0;
	int  idle_cycles    = 0;
	bit  drv_next_valid;
	bit  drv_hold;

	rx_mode_t rx_mode     = RX_FREE;
	int       rx_mode_left = 100;
	int       rx_run_left  = 0;
	bit       rx_run_high  = 1'b1;
	int       rx_cycle     = 0;
	bit       rx_next;

	multi_way_ngram_hash_slot i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.token_prev2 (token_prev2),
		.token_prev1 (token_prev1),
		.token_curr  (token_curr),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.way_index   (way_index),
		.slot_index  (slot_index),
		.last_way    (last_way)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// 64-bit avalanche finalizer
	function automatic logic [63:0] avalanche(input logic [63:0] h);
		logic [63:0] x;
		x = h ^ (h >> 16);
		x = x * AVAL_MUL_A;
		x = x ^ (x >> 13);
		x = x * AVAL_MUL_B;
		x = x ^ (x >> 16);
		return x;
	endfunction

	// Queue the slot of every way for one accepted triple
	function automatic void predict_way_slots(input token_triple_t t);
		logic [63:0] p;
		logic [63:0] h;
		way_slot_t   r;
		for (int w = 0; w < NUM_WAYS; w++) begin
			p = NGRAM_PRIME[w];
			h = {32'b0, t.curr} + {32'b0, t.prev1} * p + {32'b0, t.prev2} * p * p;
			r.way  = WAY_W'(w);
			r.slot = SLOT_W'(avalanche(h) & SLOT_MASK);
			r.last = (w == NUM_WAYS - 1);
			slot_expect.push_back(r);
		end
	endfunction

	task automatic add_triple(input logic [31:0] p2, input logic [31:0] p1,
			input logic [31:0] c);
		token_triple_t t;
		t.prev2 = p2;
		t.prev1 = p1;
		t.curr  = c;
		triple_queue.push_back(t);
		n_total++;
	endtask

	// Token ids: edge values, single bits, vocabulary-sized ids, full range
	function automatic logic [31:0] pick_token();
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0: v = 32'h0;
			1: v = 32'hffff_ffff;
			2: v = 32'h1 << $urandom_range(0, 31);
			3: v = ~(32'h1 << $urandom_range(0, 31));
			4, 5: v = $urandom_range(0, 65535);
			6: v = $urandom_range(0, 255);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Sender: bursts of requests separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			drv_hold = in_valid;
			if (in_valid && in_ready) begin
				predict_way_slots(drv_triple);
				n_accepted++;
				drv_hold = 1'b0;
			end
			if (drv_hold) begin
				drv_next_valid = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
				drv_next_valid = 1'b0;
			end else if (triple_queue.size() > 0) begin
				drv_triple = triple_queue.pop_front();
				token_prev2 <= drv_triple.prev2;
				token_prev1 <= drv_triple.prev1;
				token_curr  <= drv_triple.curr;
				drv_next_valid = 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
				end
			end else begin
				drv_next_valid = 1'b0;
			end
			in_valid <= drv_next_valid;
		end
	end

	// Receiver: stall style is redrawn whenever its mode counter runs out
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			rx_cycle++;
			if (rx_mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(64, 256);
			end else begin
				rx_mode_left--;
			end
			case (rx_mode)
				RX_FREE:   rx_next = 1'b1;
				RX_SPOTTY: rx_next = ($urandom_range(0, 3) != 0);
				RX_RUNS: begin
					if (rx_run_left == 0) begin
						rx_run_high = ~rx_run_high;
						rx_run_left = rx_run_high ? $urandom_range(1, 10) : $urandom_range(1, 24);
					end else begin
						rx_run_left--;
					end
					rx_next = rx_run_high;
				end
				default:   rx_next = ((rx_cycle % 7) < 4);
			endcase
			out_ready <= rx_next;
		end
	end

	// Result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (slot_expect.size() == 0) begin
				$error("unexpected result: way_index %0d slot_index %0h last_way %0b",
					way_index, slot_index, last_way);
				fail_count++;
			end else begin
				due = slot_expect.pop_front();
				n_checked++;
				if (way_index !== due.way) begin
					$error("way_index mismatch: expected %0d, got %0d", due.way, way_index);
					fail_count++;
				end
				if (slot_index !== due.slot) begin
					$error("slot_index mismatch (way %0d): expected %0h, got %0h",
						due.way, due.slot, slot_index);
					fail_count++;
				end
				if (last_way !== due.last) begin
					$error("last_way mismatch (way %0d): expected %0b, got %0b",
						due.way, due.last, last_way);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		int          run_len;

		// Directed: field extremes, one-hot and alternating patterns
		add_triple(32'h0, 32'h0, 32'h0);
		add_triple(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		add_triple(32'hffff_ffff, 32'h0, 32'h0);
		add_triple(32'h0, 32'hffff_ffff, 32'h0);
		add_triple(32'h0, 32'h0, 32'hffff_ffff);
		add_triple(32'h0, 32'h0, 32'h1);
		add_triple(32'h0, 32'h1, 32'h0);
		add_triple(32'h1, 32'h0, 32'h0);
		add_triple(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_triple(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
		add_triple(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
		add_triple(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		add_triple(32'h0000_ffff, 32'hffff_0000, 32'h00ff_ff00);
		add_triple(32'd50256, 32'd50256, 32'd50256);
		add_triple(32'd1, 32'd2, 32'd3);
		add_triple(32'd2, 32'd3, 32'd4);
		add_triple(32'hffff_ffff, 32'h0, 32'hffff_ffff);
		add_triple(32'h0, 32'hffff_ffff, 32'hffff_ffff);
		n_directed = n_total;

		// Random: mostly sliding n-gram streams, the rest loose triples
		while (n_total < n_directed + N_RANDOM) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					a = pick_token();
					b = pick_token();
					run_len = $urandom_range(3, 12);
					for (int k = 0; k < run_len && n_total < n_directed + N_RANDOM; k++) begin
						c = pick_token();
						add_triple(a, b, c);
						a = b;
						b = c;
					end
				end
				6, 7: add_triple($urandom, $urandom, $urandom);
				default: add_triple(pick_token(), pick_token(), pick_token());
			endcase
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (n_accepted < n_total || slot_expect.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d token triples (%0d directed, rest random streams and loose triples),",
			n_total, n_directed);
		$display("checked %0d way slots over %0d ways with bursty sender and stalling receiver.",
			n_checked, NUM_WAYS);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* sim.f */
hdl/mwnh_pkg.sv
hdl/mwnh_issue.sv
hdl/mwnh_mix_pipe.sv
hdl/multi_way_ngram_hash_slot.sv
tb/multi_way_ngram_hash_slot_tb.sv
